[hdl/fr_pkg.sv]
// ----------------------------------------------------------------------------
// fr_pkg
// Types, widths and helpers shared by the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int CW       = 16;               // direction component width
  localparam int PROD_W   = 2 * CW;
  localparam int F2       = 2 * (CW - 2);     // fraction bits of a raw product
  localparam int SH_R     = (F2 >= 30) ? F2 - 30 : 0;
  localparam int SH_L     = (F2 < 30) ? 30 - F2 : 0;
  localparam int P30_W    = 34;               // one product in Q.30
  localparam int DOT_W    = 36;               // sum of three products
  localparam int ETA_W    = 16;
  localparam int ROOT_W   = 31;               // Q1.30 magnitudes
  localparam int RAD_W    = 61;               // radicand, up to 2^60
  localparam int NUM_W    = 47;               // eta * Q1.30
  localparam int RN_W     = 48;               // ratio numerator / denominator
  localparam int SQ_W     = 62;
  localparam int SUM_W    = 63;
  localparam int REFL_W   = 17;
  localparam int STEPS    = 2;                // iterations per stage
  localparam int ITER     = 31;
  localparam int STAGES   = (ITER + STEPS - 1) / STEPS;

  localparam logic [ETA_W-1:0]        ONE_Q12  = ETA_W'(4096);
  localparam logic signed [DOT_W-1:0] DOT_ONE  = DOT_W'(1 << 30);
  localparam logic [RAD_W-1:0]        ONE_Q60  = RAD_W'(1) << 60;
  localparam logic [SUM_W-1:0]        RND_HALF = SUM_W'(1) << 43;
  localparam logic [REFL_W-1:0]       REFL_ONE = REFL_W'(65536);

  typedef struct packed {
    logic signed [CW-1:0] incident_x;
    logic signed [CW-1:0] incident_y;
    logic signed [CW-1:0] incident_z;
    logic signed [CW-1:0] normal_x;
    logic signed [CW-1:0] normal_y;
    logic signed [CW-1:0] normal_z;
    logic [15:0]          ior;
  } hit_t;

  typedef struct packed {
    logic [REFL_W-1:0] reflectance;
    logic              total_reflection;
  } refl_t;

  typedef struct packed {
    logic [ROOT_W-1:0] c;
    logic [ETA_W-1:0]  eta_i;
    logic [ETA_W-1:0]  eta_t;
    logic              tir;
  } side_t;

  // product of two Q2.F components brought to Q.30, floor rounding
  function automatic logic signed [P30_W-1:0] prod_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W+31:0] w;
    w = (PROD_W+32)'(p);
    w = (w >>> SH_R) <<< SH_L;
    return w[P30_W-1:0];
  endfunction

endpackage

[hdl/fr_sqrt.sv]
// ----------------------------------------------------------------------------
// fr_sqrt
// Pipelined integer square root of a 61-bit radicand, two result bits a stage.
// ----------------------------------------------------------------------------
module fr_sqrt import fr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid,
  input  logic [RAD_W-1:0]  rad,
  input  side_t             side,
  output logic              root_valid,
  output logic [ROOT_W-1:0] root,
  output side_t             root_side
);

  logic             v    [0:STAGES];
  logic [RAD_W-1:0] rem  [0:STAGES];
  logic [RAD_W:0]   acc  [0:STAGES];
  side_t            sd   [0:STAGES];

  assign v[0]   = valid;
  assign rem[0] = rad;
  assign acc[0] = '0;
  assign sd[0]  = side;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [RAD_W-1:0] rem_next;
    logic [RAD_W:0]   acc_next;

    always_comb begin
      logic [RAD_W:0] bitv;
      logic [RAD_W:0] trial;
      bitv     = '0;
      trial    = '0;
      rem_next = rem[g];
      acc_next = acc[g];
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < ITER) begin
          bitv  = (RAD_W+1)'(1) << (2 * (ITER - 1 - (g * STEPS + j)));
          trial = acc_next + bitv;
          if ({1'b0, rem_next} >= trial) begin
            rem_next = rem_next - trial[RAD_W-1:0];
            acc_next = (acc_next >> 1) + bitv;
          end else begin
            acc_next = acc_next >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= rem_next;
        acc[g+1] <= acc_next;
        sd[g+1]  <= sd[g];
      end
    end
  end

  assign root_valid = v[STAGES];
  assign root       = acc[STAGES][ROOT_W-1:0];
  assign root_side  = sd[STAGES];

endmodule

[hdl/fr_sindiv.sv]
// ----------------------------------------------------------------------------
// fr_sindiv
// Pipelined restoring divider for Snell's law: sinT = etaI*sinI / etaT.
// Flags total reflection when the quotient reaches 1.0 in Q1.30.
// ----------------------------------------------------------------------------
module fr_sindiv import fr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid,
  input  logic [NUM_W-1:0]  num,
  input  side_t             side,
  output logic              quo_valid,
  output logic [ROOT_W-1:0] quo,
  output side_t             quo_side
);

  logic              v    [0:STAGES];
  logic [ETA_W-1:0]  rem  [0:STAGES];
  logic [ITER-1:0]   nlo  [0:STAGES];
  logic [ROOT_W-1:0] q    [0:STAGES];
  logic              ovf  [0:STAGES];
  side_t             sd   [0:STAGES];

  logic [ETA_W-1:0] pre;

  assign pre    = num[NUM_W-1:ITER];
  assign v[0]   = valid;
  assign ovf[0] = (pre >= side.eta_t);
  assign rem[0] = ovf[0] ? '0 : pre;
  assign nlo[0] = num[ITER-1:0];
  assign q[0]   = '0;
  assign sd[0]  = side;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [ETA_W-1:0]  rem_next;
    logic [ITER-1:0]   nlo_next;
    logic [ROOT_W-1:0] q_next;

    always_comb begin
      logic [ETA_W:0] t;
      t        = '0;
      rem_next = rem[g];
      nlo_next = nlo[g];
      q_next   = q[g];
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < ITER) begin
          t        = {rem_next, nlo_next[ITER-1]};
          nlo_next = nlo_next << 1;
          if (t >= {1'b0, sd[g].eta_t}) begin
            t        = t - {1'b0, sd[g].eta_t};
            q_next   = {q_next[ROOT_W-2:0], 1'b1};
          end else begin
            q_next   = {q_next[ROOT_W-2:0], 1'b0};
          end
          rem_next = t[ETA_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= rem_next;
        nlo[g+1] <= nlo_next;
        q[g+1]   <= q_next;
        ovf[g+1] <= ovf[g];
        sd[g+1]  <= sd[g];
      end
    end
  end

  always_comb begin
    quo_side     = sd[STAGES];
    quo_side.tir = ovf[STAGES] | q[STAGES][ROOT_W-1];
  end

  assign quo_valid = v[STAGES];
  assign quo       = q[STAGES];

endmodule

[hdl/fr_ratio.sv]
// ----------------------------------------------------------------------------
// fr_ratio
// Two-lane pipelined fractional divider: floor(n * 2^30 / d) for n <= d.
// ----------------------------------------------------------------------------
module fr_ratio import fr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid,
  input  logic [RN_W-1:0]   num_a,
  input  logic [RN_W-1:0]   den_a,
  input  logic [RN_W-1:0]   num_b,
  input  logic [RN_W-1:0]   den_b,
  input  side_t             side,
  output logic              ratio_valid,
  output logic [ROOT_W-1:0] ratio_a,
  output logic [ROOT_W-1:0] ratio_b,
  output side_t             ratio_side
);

  logic              v    [0:STAGES];
  logic [RN_W-1:0]   rem  [0:STAGES][0:1];
  logic [RN_W-1:0]   den  [0:STAGES][0:1];
  logic [ROOT_W-1:0] q    [0:STAGES][0:1];
  logic              zero [0:STAGES][0:1];
  side_t             sd   [0:STAGES];

  assign v[0]       = valid;
  assign sd[0]      = side;
  assign rem[0][0]  = num_a;
  assign rem[0][1]  = num_b;
  assign den[0][0]  = den_a;
  assign den[0][1]  = den_b;
  assign q[0][0]    = '0;
  assign q[0][1]    = '0;
  assign zero[0][0] = (den_a == '0);
  assign zero[0][1] = (den_b == '0);

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [RN_W-1:0]   rem_next [0:1];
    logic [ROOT_W-1:0] q_next   [0:1];

    always_comb begin
      logic [RN_W:0] t;
      t = '0;
      for (int l = 0; l < 2; l++) begin
        rem_next[l] = rem[g][l];
        q_next[l]   = q[g][l];
        for (int j = 0; j < STEPS; j++) begin
          if (g * STEPS + j < ITER) begin
            if (g * STEPS + j == 0) begin
              t = {1'b0, rem_next[l]};
            end else begin
              t = {rem_next[l], 1'b0};
            end
            if (t >= {1'b0, den[g][l]}) begin
              t         = t - {1'b0, den[g][l]};
              q_next[l] = {q_next[l][ROOT_W-2:0], 1'b1};
            end else begin
              q_next[l] = {q_next[l][ROOT_W-2:0], 1'b0};
            end
            rem_next[l] = t[RN_W-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[g+1] <= sd[g];
        for (int l = 0; l < 2; l++) begin
          rem[g+1][l]  <= rem_next[l];
          den[g+1][l]  <= den[g][l];
          q[g+1][l]    <= q_next[l];
          zero[g+1][l] <= zero[g][l];
        end
      end
    end
  end

  assign ratio_valid = v[STAGES];
  assign ratio_a     = zero[STAGES][0] ? '0 : q[STAGES][0];
  assign ratio_b     = zero[STAGES][1] ? '0 : q[STAGES][1];
  assign ratio_side  = sd[STAGES];

endmodule

[hdl/fresnel_reflectance.sv]
// ----------------------------------------------------------------------------
// fresnel_reflectance
// Unpolarized Fresnel reflectance of a surface hit, fully pipelined.
//
//   channel  dir  payload  handshake
//   hit      in   hit_t    hit_valid / hit_stall
//   refl     out  refl_t   refl_valid / refl_stall
//
// One transfer per cycle while the result is not stalled; the depth comes mostly from the
// two 16-stage square roots and the two 16-stage dividers (two iterations per stage).
// rst is synchronous and clears all valid bits.
// A stalled result freezes the whole pipeline; hit_stall follows at once.
// ----------------------------------------------------------------------------
module fresnel_reflectance import fr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  hit_valid,
  output logic  hit_stall,
  input  hit_t  hit,
  output logic  refl_valid,
  input  logic  refl_stall,
  output refl_t refl
);

  logic en;
  assign en        = !(refl_valid && refl_stall);
  assign hit_stall = !en;

  // stage 1: component products
  logic                    s1_v;
  logic signed [P30_W-1:0] s1_p [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p[0] <= prod_q30(hit.incident_x * hit.normal_x);
      s1_p[1] <= prod_q30(hit.incident_y * hit.normal_y);
      s1_p[2] <= prod_q30(hit.incident_z * hit.normal_z);
    end
  end

  logic [15:0] ior_c;
  logic [15:0] ior_d;
  assign ior_c = (hit.ior < ONE_Q12) ? ONE_Q12 : hit.ior;

  always_ff @(posedge clk) begin
    if (en) begin
      ior_d <= ior_c;
    end
  end

  // stage 2: cosine, clamp, index selection
  logic                    s2_v;
  side_t                   s2_side;
  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] dot_cl;
  logic [DOT_W-1:0]        dot_mag;
  side_t                   s2_side_next;

  always_comb begin
    dot = DOT_W'(s1_p[0]) + DOT_W'(s1_p[1]) + DOT_W'(s1_p[2]);
    if (dot > DOT_ONE) begin
      dot_cl = DOT_ONE;
    end else if (dot < -DOT_ONE) begin
      dot_cl = -DOT_ONE;
    end else begin
      dot_cl = dot;
    end
    dot_mag            = dot_cl[DOT_W-1] ? DOT_W'(-dot_cl) : DOT_W'(dot_cl);
    s2_side_next.c     = dot_mag[ROOT_W-1:0];
    s2_side_next.eta_i = dot_cl[DOT_W-1] ? ONE_Q12 : ior_d;
    s2_side_next.eta_t = dot_cl[DOT_W-1] ? ior_d : ONE_Q12;
    s2_side_next.tir   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s2_side_next;
    end
  end

  // stage 3: 1 - c^2
  logic             s3_v;
  logic [RAD_W-1:0] s3_rad;
  side_t            s3_side;
  logic [SQ_W-1:0]  csq;

  assign csq = SQ_W'(s2_side.c) * SQ_W'(s2_side.c);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rad  <= ONE_Q60 - csq[RAD_W-1:0];
      s3_side <= s2_side;
    end
  end

  // sinI
  logic              q1_v;
  logic [ROOT_W-1:0] sin_i;
  side_t             q1_side;

  fr_sqrt u_sqrt_sin (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid      (s3_v),
    .rad        (s3_rad),
    .side       (s3_side),
    .root_valid (q1_v),
    .root       (sin_i),
    .root_side  (q1_side)
  );

  // stage 4: etaI * sinI
  logic             s4_v;
  logic [NUM_W-1:0] s4_num;
  side_t            s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= q1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_num  <= NUM_W'(q1_side.eta_i) * NUM_W'(sin_i);
      s4_side <= q1_side;
    end
  end

  // sinT
  logic              dv_v;
  logic [ROOT_W-1:0] sin_t;
  side_t             dv_side;

  fr_sindiv u_sindiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (s4_v),
    .num       (s4_num),
    .side      (s4_side),
    .quo_valid (dv_v),
    .quo       (sin_t),
    .quo_side  (dv_side)
  );

  // stage 5: 1 - sinT^2
  logic              s5_v;
  logic [RAD_W-1:0]  s5_rad;
  side_t             s5_side;
  logic [RAD_W-2:0]  ssq;

  assign ssq = (RAD_W-1)'(sin_t[ROOT_W-2:0]) * (RAD_W-1)'(sin_t[ROOT_W-2:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rad  <= ONE_Q60 - RAD_W'(ssq);
      s5_side <= dv_side;
    end
  end

  // cosT
  logic              q2_v;
  logic [ROOT_W-1:0] cos_t;
  side_t             q2_side;

  fr_sqrt u_sqrt_cos (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid      (s5_v),
    .rad        (s5_rad),
    .side       (s5_side),
    .root_valid (q2_v),
    .root       (cos_t),
    .root_side  (q2_side)
  );

  // stage 6: cross products
  logic             s6_v;
  logic [NUM_W-1:0] s6_tc, s6_ic, s6_icos, s6_tcos;
  side_t            s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= q2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tc   <= NUM_W'(q2_side.eta_t) * NUM_W'(q2_side.c);
      s6_icos <= NUM_W'(q2_side.eta_i) * NUM_W'(cos_t);
      s6_ic   <= NUM_W'(q2_side.eta_i) * NUM_W'(q2_side.c);
      s6_tcos <= NUM_W'(q2_side.eta_t) * NUM_W'(cos_t);
      s6_side <= q2_side;
    end
  end

  // stage 7: numerators and denominators
  logic            s7_v;
  logic [RN_W-1:0] s7_na, s7_da, s7_nb, s7_db;
  side_t           s7_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_da   <= RN_W'(s6_tc) + RN_W'(s6_icos);
      s7_na   <= (s6_tc >= s6_icos) ? RN_W'(s6_tc - s6_icos) : RN_W'(s6_icos - s6_tc);
      s7_db   <= RN_W'(s6_ic) + RN_W'(s6_tcos);
      s7_nb   <= (s6_ic >= s6_tcos) ? RN_W'(s6_ic - s6_tcos) : RN_W'(s6_tcos - s6_ic);
      s7_side <= s6_side;
    end
  end

  // Rpar, Rperp
  logic              rt_v;
  logic [ROOT_W-1:0] rpar, rperp;
  side_t             rt_side;

  fr_ratio u_ratio (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .valid       (s7_v),
    .num_a       (s7_na),
    .den_a       (s7_da),
    .num_b       (s7_nb),
    .den_b       (s7_db),
    .side        (s7_side),
    .ratio_valid (rt_v),
    .ratio_a     (rpar),
    .ratio_b     (rperp),
    .ratio_side  (rt_side)
  );

  // stage 8: squares
  logic            s8_v;
  logic [SQ_W-1:0] s8_sa, s8_sb;
  logic            s8_tir;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_sa  <= SQ_W'(rpar) * SQ_W'(rpar);
      s8_sb  <= SQ_W'(rperp) * SQ_W'(rperp);
      s8_tir <= rt_side.tir;
    end
  end

  // output register: mean, round, clamp; total reflection forces full reflectance
  logic [SUM_W-1:0]  rsum;
  logic [SUM_W-1:0]  rnd;
  refl_t             refl_next;

  always_comb begin
    rsum = (SUM_W'(s8_sa) + SUM_W'(s8_sb)) >> 1;
    rnd  = rsum + RND_HALF;
    if (s8_tir) begin
      refl_next.reflectance      = REFL_ONE;
      refl_next.total_reflection = 1'b1;
    end else begin
      refl_next.reflectance      = (rnd[SUM_W-1:44] > (SUM_W-44)'(REFL_ONE)) ?
                                   REFL_ONE : rnd[44+REFL_W-1:44];
      refl_next.total_reflection = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refl_valid <= 1'b0;
    end else if (en) begin
      refl_valid <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      refl <= refl_next;
    end
  end

endmodule

[hdl/fr_checker.sv]
// ----------------------------------------------------------------------------
// fr_checker
// Port-level checks for fresnel_reflectance, bound to the top level.
// ----------------------------------------------------------------------------
module fr_checker import fr_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  hit_stall,
  input logic  refl_valid,
  input logic  refl_stall,
  input refl_t refl
);

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    hit_stall == (refl_valid && refl_stall))
    else $error("hit_stall does not follow the result stall");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !refl_valid)
    else $error("result valid after reset");

  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    refl_valid && refl.total_reflection |-> refl.reflectance == REFL_ONE)
    else $error("total reflection without full reflectance");

  a_range: assert property (@(posedge clk) disable iff (rst)
    refl_valid |-> refl.reflectance <= REFL_ONE)
    else $error("reflectance above 1.0");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    refl_valid && refl_stall |=> refl_valid && $stable(refl))
    else $error("stalled result transfer changed");

endmodule

bind fresnel_reflectance fr_checker u_fr_checker (
  .clk        (clk),
  .rst        (rst),
  .hit_stall  (hit_stall),
  .refl_valid (refl_valid),
  .refl_stall (refl_stall),
  .refl       (refl)
);
